// ===== src/wps_pkg.sv =====
// Waypoint patrol steering package: fixed widths, CORDIC angle table, FSM and mode codes.
// No dependencies.
package wps_pkg;
  localparam int POS_W = 20;
  localparam int DIF_W = 21;
  localparam int CX_W  = 26;
  localparam int Z_W   = 26;
  localparam int D2_W  = 44;
  localparam int ATAN_LEN = 24;
  localparam logic [Z_W-1:0] DEG90_Z = 26'd5898240;
  localparam logic [1:0] REG_REPEAT = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RD    = 7'b0000010,
    ST_DIST  = 7'b0000100,
    ST_RD2   = 7'b0001000,
    ST_PREP  = 7'b0010000,
    ST_CORD  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  function automatic logic [Z_W-1:0] atan_of(input logic [4:0] i);
    logic [Z_W-1:0] r;
    begin
      case (i)
        5'd0: r = 26'd2949120;  5'd1: r = 26'd1740967; 5'd2: r = 26'd919879;
        5'd3: r = 26'd466945;   5'd4: r = 26'd234379;  5'd5: r = 26'd117304;
        5'd6: r = 26'd58666;    5'd7: r = 26'd29335;   5'd8: r = 26'd14668;
        5'd9: r = 26'd7334;     5'd10: r = 26'd3667;   5'd11: r = 26'd1833;
        5'd12: r = 26'd917;     5'd13: r = 26'd458;    5'd14: r = 26'd229;
        5'd15: r = 26'd115;     5'd16: r = 26'd57;     5'd17: r = 26'd29;
        5'd18: r = 26'd14;      5'd19: r = 26'd7;      5'd20: r = 26'd4;
        5'd21: r = 26'd2;       5'd22: r = 26'd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction
endpackage

// ===== src/wps_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module wps_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== src/waypoint_patrol_steering_core.sv =====
// Waypoint patrol steering top level: control FSM, serial distance check, CORDIC.
// Depends on wps_pkg and wps_ram.
//
// Usage: raise start with in_mode/in_pos_x/in_pos_y/in_heading while busy is
// low. A load word (mode 0) appends a waypoint unless the table is full; it gives no result.
// A tick word (mode 1) gives one result strobed by out_valid for one cycle.
// Tick sequence: busy covers a table read, the squared distance (latch,
// one multiplier bit per cycle on both axes for 20 bits, compare), one more
// read when the waypoint is reached, a pre-rotation state, CORDIC_STEPS
// iterations (capped at ATAN_LEN) of one shared shift-add unit and an output
// state; a stopped tick goes from the table read straight to the output state.
// out_valid is high in the cycle after the output state, when busy is already
// low, so the next word may be accepted in the cycle the result is strobed.
// The receiver cannot stall; results are shown for exactly one cycle.
// Registers over APB at cfg_paddr 0 (repeat_enable) and 4 (reach_radius_mm).
// Reset (rst_n low, synchronous) empties the table, clears index and done,
// repeat to 0 and radius to 300. Waypoint storage is not cleared.
module waypoint_patrol_steering_core #(
  parameter int MAX_WAYPOINTS = 64,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic signed [19:0] in_pos_x,
  input  logic signed [19:0] in_pos_y,
  input  logic signed [12:0] in_heading,
  output logic               out_valid,
  output logic signed [11:0] out_yaw_command,
  output logic [9:0]         out_forward_command,
  output logic               out_patrol_done,
  output logic [5:0]         out_target_index,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);
  localparam int STEPS = (CORDIC_STEPS > wps_pkg::ATAN_LEN) ? wps_pkg::ATAN_LEN
                                                           : CORDIC_STEPS;
  localparam int PW = wps_pkg::POS_W;
  localparam int DW = wps_pkg::DIF_W;
  localparam int XW = wps_pkg::CX_W;
  localparam int ZW = wps_pkg::Z_W;
  localparam int QW = wps_pkg::D2_W;

  wps_pkg::state_t st_r, st_nxt;
  logic           rep_r;
  logic [15:0]    rad_r;
  logic [CW-1:0]  cnt_r;
  logic [AW-1:0]  idx_r;
  logic           fin_r;
  logic signed [PW-1:0] px_r, py_r;
  logic signed [12:0]   hd_r;
  logic [AW-1:0]  addr;
  logic           we;
  logic [2*PW-1:0] rdata;
  logic [4:0]     bit_r;
  logic [DW-1:0]  ax_r, ay_r, mx_r, my_r;
  logic [QW-1:0]  acc_r;
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic           zero_r;
  logic           cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'd0, rep_r} : {16'd0, rad_r};
  assign busy = (st_r != wps_pkg::ST_IDLE);

  wps_ram #(.WIDTH(2*PW), .DEPTH(MAX_WAYPOINTS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata({px_r, py_r}), .rdata(rdata)
  );

  logic            load_r;
  logic signed [DW-1:0] dx, dy;
  assign dx = DW'(signed'(rdata[2*PW-1:PW])) - DW'(px_r);
  assign dy = DW'(signed'(rdata[PW-1:0])) - DW'(py_r);
  assign we = load_r && (cnt_r < CW'(MAX_WAYPOINTS));
  assign addr = load_r ? cnt_r[AW-1:0] : idx_r;

  logic reached, last;
  assign reached = acc_r <= QW'({16'd0, rad_r} * {16'd0, rad_r});
  assign last = (CW'(idx_r) + CW'(1)) >= cnt_r;

  // CORDIC step with arithmetic shifts
  logic signed [XW-1:0] xs, ys;
  logic [4:0] ci;
  assign ci = bit_r;
  assign xs = cx_r >>> ci;
  assign ys = cy_r >>> ci;

  // output math
  logic signed [ZW-1:0] zr;
  logic signed [14:0]   b16, e;
  logic signed [14:0]   w;
  logic signed [11:0]   yc;
  logic [10:0]          ay;
  assign zr  = (cz_r + ZW'(2048)) >>> 12;
  assign b16 = zero_r ? 15'sd0 : zr[14:0];
  assign e   = b16 - 15'(hd_r);
  always_comb begin
    w = e;
    if (w >= 15'sd2880) w = w - 15'sd5760;
    if (w >= 15'sd2880) w = w - 15'sd5760;
    if (w < -15'sd2880) w = w + 15'sd5760;
    if (w < -15'sd2880) w = w + 15'sd5760;
    if (w > 15'sd1600) w = 15'sd1600;
    if (w < -15'sd1600) w = -15'sd1600;
    yc = w[11:0];
    ay = yc[11] ? 11'(-w) : 11'(w);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      wps_pkg::ST_IDLE: if (start) st_nxt = (in_mode == wps_pkg::MODE_TICK) ? wps_pkg::ST_RD
                                                                         : wps_pkg::ST_OUT;
      wps_pkg::ST_RD:   st_nxt = (fin_r || cnt_r == '0) ? wps_pkg::ST_OUT : wps_pkg::ST_DIST;
      wps_pkg::ST_DIST: if (bit_r == 5'(DW)) st_nxt = reached ? wps_pkg::ST_RD2
                                                              : wps_pkg::ST_PREP;
      wps_pkg::ST_RD2:  st_nxt = wps_pkg::ST_PREP;
      wps_pkg::ST_PREP: st_nxt = wps_pkg::ST_CORD;
      wps_pkg::ST_CORD: if (bit_r == 5'(STEPS - 1)) st_nxt = wps_pkg::ST_OUT;
      wps_pkg::ST_OUT:  st_nxt = wps_pkg::ST_IDLE;
      default:          st_nxt = wps_pkg::ST_IDLE;
    endcase
  end

  logic stopped_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wps_pkg::ST_IDLE;
      rep_r <= 1'b0; rad_r <= 16'd300;
      cnt_r <= '0; idx_r <= '0; fin_r <= 1'b0;
      load_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= 1'b0;
      if (cfg_wr && cfg_paddr[1:0] == 2'd0) begin
        if (cfg_paddr[2] == wps_pkg::REG_REPEAT[0]) begin
          rep_r <= cfg_pwdata[0];
          if (cfg_pwdata[0]) fin_r <= 1'b0;
        end else if (cfg_paddr[2] == wps_pkg::REG_RADIUS[0]) begin
          rad_r <= cfg_pwdata[15:0];
        end
      end
      case (st_r)
        wps_pkg::ST_IDLE: begin
          load_r <= start & (in_mode == wps_pkg::MODE_LOAD);
          px_r <= in_pos_x; py_r <= in_pos_y; hd_r <= in_heading;
        end
        wps_pkg::ST_RD: begin
          stopped_r <= fin_r || cnt_r == '0;
          bit_r <= '0; acc_r <= '0;
        end
        wps_pkg::ST_DIST: begin
          if (bit_r == 5'd0) begin
            // latch |d| and multiplier copies
            ax_r <= dx[DW-1] ? DW'(-dx) : dx; ay_r <= dy[DW-1] ? DW'(-dy) : dy;
            mx_r <= dx[DW-1] ? DW'(-dx) : dx; my_r <= dy[DW-1] ? DW'(-dy) : dy;
            cx_r <= XW'(dx); cy_r <= XW'(dy);
            zero_r <= (dx == '0) && (dy == '0);
            bit_r <= 5'd1;
          end else if (bit_r != 5'(DW)) begin
            // one multiplier bit per cycle for each axis
            acc_r <= acc_r
                     + (mx_r[0] ? (QW'(ax_r) << (bit_r - 5'd1)) : '0)
                     + (my_r[0] ? (QW'(ay_r) << (bit_r - 5'd1)) : '0);
            mx_r <= mx_r >> 1; my_r <= my_r >> 1;
            bit_r <= bit_r + 5'd1;
          end else if (reached) begin
            if (!rep_r && last) begin
              idx_r <= '0; fin_r <= 1'b1;
            end else begin
              idx_r <= last ? '0 : idx_r + AW'(1);
            end
          end
        end
        wps_pkg::ST_RD2: ;
        wps_pkg::ST_PREP: begin
          // rdata holds the current target here; rotate a left-half vector by 90 degrees
          zero_r <= (dx == '0) && (dy == '0);
          if (dx < 0) begin
            if (dy >= 0) begin
              cx_r <= XW'(dy); cy_r <= XW'(-dx); cz_r <= ZW'(wps_pkg::DEG90_Z);
            end else begin
              cx_r <= XW'(-dy); cy_r <= XW'(dx); cz_r <= -ZW'(wps_pkg::DEG90_Z);
            end
          end else begin
            cx_r <= XW'(dx); cy_r <= XW'(dy); cz_r <= '0;
          end
          bit_r <= '0;
        end
        wps_pkg::ST_CORD: begin
          if (cy_r >= 0) begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + ZW'(wps_pkg::atan_of(ci));
          end else begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - ZW'(wps_pkg::atan_of(ci));
          end
          bit_r <= bit_r + 5'd1;
        end
        wps_pkg::ST_OUT: begin
          if (load_r) begin
            if (cnt_r < CW'(MAX_WAYPOINTS)) cnt_r <= cnt_r + CW'(1);
            load_r <= 1'b0;
          end else begin
            out_valid <= 1'b1;
            out_patrol_done <= fin_r;
            out_target_index <= 6'(idx_r);
            out_yaw_command <= stopped_r ? 12'sd0 : yc;
            out_forward_command <= (stopped_r || ay >= 11'd960) ? 10'd0
                                   : 10'(11'd960 - ay);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== test/waypoint_patrol_steering_core_test.sv =====
// Testbench for waypoint_patrol_steering_core: drives load and tick words,
// predicts each steering command and checks it. Depends on wps_pkg and the core.
module waypoint_patrol_steering_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_WP = 64;
  localparam int STEPS = 16;
  localparam int SETTLE = 80;
  localparam int LIMIT = 400000;
  localparam longint HALF_TURN = 2880;
  localparam longint FULL_TURN = 5760;
  localparam longint YAW_LIM = 1600;
  localparam longint FWD_FULL = 960;

  typedef struct {
    logic               mode;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [12:0] hd;
  } word_t;

  typedef struct {
    logic signed [11:0] yaw;
    logic [9:0]         fwd;
    logic               done;
    logic [5:0]         idx;
  } steer_t;

  logic clk, rst_n, start, busy;
  logic in_mode;
  logic signed [19:0] in_pos_x, in_pos_y;
  logic signed [12:0] in_heading;
  logic out_valid, out_patrol_done;
  logic signed [11:0] out_yaw_command;
  logic [9:0] out_forward_command;
  logic [5:0] out_target_index;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  waypoint_patrol_steering_core DUT (.*);

  // steering state mirror
  longint wp_x[NUM_WP], wp_y[NUM_WP];
  int wp_count, cur_idx;
  bit patrol_finished, loop_patrol;
  longint reach_mm;

  word_t word_queue[$];
  steer_t expected_cmds[$];
  word_t held_word;
  int burst_left, gap_left;
  int errors, cycles, ticks_checked, loads_sent;

  // generator shadow of loaded waypoints
  longint gen_x[$], gen_y[$];
  int gen_next;

  function automatic longint bearing16(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    x = dx; y = dy; z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 5898240;
      end else begin
        t = x; x = -y; y = t; z = -5898240;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(wps_pkg::atan_of(5'(i)));
      end else begin
        x -= ys; y += xs; z -= longint'(wps_pkg::atan_of(5'(i)));
      end
    end
    return (z + 2048) >>> 12;
  endfunction

  function automatic void steer_word(word_t w);
    longint dx, dy, yaw, fwd;
    steer_t r;
    if (w.mode == wps_pkg::MODE_LOAD) begin
      if (wp_count < NUM_WP) begin
        wp_x[wp_count] = w.x;
        wp_y[wp_count] = w.y;
        wp_count++;
      end
      return;
    end
    yaw = 0; fwd = 0;
    if (!patrol_finished && wp_count > 0) begin
      dx = wp_x[cur_idx] - longint'(w.x);
      dy = wp_y[cur_idx] - longint'(w.y);
      if (dx * dx + dy * dy <= reach_mm * reach_mm) begin
        if (!loop_patrol && cur_idx + 1 >= wp_count) begin
          cur_idx = 0;
          patrol_finished = 1;
        end else begin
          cur_idx = (cur_idx + 1) % wp_count;
        end
        dx = wp_x[cur_idx] - longint'(w.x);
        dy = wp_y[cur_idx] - longint'(w.y);
      end
      yaw = (bearing16(dx, dy) - longint'(w.hd) + HALF_TURN) % FULL_TURN;
      if (yaw < 0) yaw += FULL_TURN;
      yaw -= HALF_TURN;
      if (yaw > YAW_LIM) yaw = YAW_LIM;
      if (yaw < -YAW_LIM) yaw = -YAW_LIM;
      fwd = FWD_FULL - (yaw < 0 ? -yaw : yaw);
      if (fwd < 0) fwd = 0;
    end
    r.yaw = 12'(yaw);
    r.fwd = 10'(fwd);
    r.done = patrol_finished;
    r.idx = 6'(cur_idx);
    expected_cmds.insert(expected_cmds.size(), r);
  endfunction

  function automatic void push_word(logic mode, longint x, longint y, longint hd);
    word_t w;
    w.mode = mode; w.x = 20'(x); w.y = 20'(y); w.hd = 13'(hd);
    if (mode == wps_pkg::MODE_LOAD && gen_x.size() < NUM_WP) begin
      gen_x.insert(gen_x.size(), longint'(w.x));
      gen_y.insert(gen_y.size(), longint'(w.y));
    end
    word_queue.insert(word_queue.size(), w);
  endfunction

  function automatic longint any_pos();
    case ($urandom_range(0, 5))
      0: return -524288;
      1: return 524287;
      default: return longint'($signed(20'($urandom)));
    endcase
  endfunction

  // random words: loads, ticks near a loaded waypoint taken in turn, and wild ticks
  function automatic void random_words(int n, int load_pct, int span);
    longint hd;
    int k;
    for (int i = 0; i < n; i++) begin
      hd = ($urandom_range(0, 3) == 0) ? longint'($signed(13'($urandom)))
                                        : longint'($urandom_range(0, 5760)) - 2880;
      if ($urandom_range(0, 99) < load_pct) begin
        push_word(wps_pkg::MODE_LOAD, any_pos(), any_pos(), hd);
      end else if (gen_x.size() > 0 && $urandom_range(0, 9) < 7) begin
        k = gen_next % gen_x.size();
        gen_next++;
        push_word(wps_pkg::MODE_TICK, gen_x[k] + $urandom_range(0, 2 * span) - span,
                  gen_y[k] + $urandom_range(0, 2 * span) - span, hd);
      end else begin
        push_word(wps_pkg::MODE_TICK, any_pos(), any_pos(), hd);
      end
    end
  endfunction

  task automatic wait_idle();
    while (word_queue.size() > 0 || start || expected_cmds.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] index, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= 3'(index * 4);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    if (index == wps_pkg::REG_REPEAT) begin
      loop_patrol = value[0];
      if (loop_patrol) patrol_finished = 0;
    end else if (index == wps_pkg::REG_RADIUS) begin
      reach_mm = longint'(value[15:0]);
    end
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: bursts of words separated by random gaps
  always @(posedge clk) begin
    if (start && !busy) steer_word(held_word);
    if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 0;
      end else if (word_queue.size() > 0 && rst_n) begin
        held_word = word_queue.pop_front();
        if (held_word.mode == wps_pkg::MODE_LOAD) loads_sent++;
        start <= 1;
        in_mode <= held_word.mode;
        in_pos_x <= held_word.x;
        in_pos_y <= held_word.y;
        in_heading <= held_word.hd;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 0;
      end
    end
  end

  // monitor: compare every strobed command with the oldest prediction
  always @(posedge clk) begin
    steer_t e;
    if (rst_n && out_valid) begin
      if (expected_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected command yaw=%0d fwd=%0d", $time,
                 out_yaw_command, out_forward_command);
      end else begin
        e = expected_cmds.pop_front();
        ticks_checked++;
        if (out_yaw_command !== e.yaw) begin
          errors++;
          $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, out_yaw_command);
        end
        if (out_forward_command !== e.fwd) begin
          errors++;
          $display("%0t: forward expected %0d actual %0d", $time, e.fwd,
                   out_forward_command);
        end
        if (out_patrol_done !== e.done) begin
          errors++;
          $display("%0t: done expected %0d actual %0d", $time, e.done, out_patrol_done);
        end
        if (out_target_index !== e.idx) begin
          errors++;
          $display("%0t: index expected %0d actual %0d", $time, e.idx, out_target_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("waypoint_patrol_steering_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n <= 0; start <= 0; in_mode <= 0; in_pos_x <= 0; in_pos_y <= 0; in_heading <= 0;
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0; cfg_paddr <= 0; cfg_pwdata <= 0;
    burst_left = 1; gap_left = 0; errors = 0; cycles = 0; ticks_checked = 0;
    loads_sent = 0; gen_next = 0;
    wp_count = 0; cur_idx = 0; patrol_finished = 0; loop_patrol = 0; reach_mm = 300;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // empty table, a short patrol that ends on its own start point
    push_word(wps_pkg::MODE_TICK, 0, 0, -4096);
    push_word(wps_pkg::MODE_LOAD, 0, 0, 4095);
    push_word(wps_pkg::MODE_LOAD, 524287, -524288, 0);
    push_word(wps_pkg::MODE_LOAD, -524288, 524287, 0);
    push_word(wps_pkg::MODE_LOAD, 0, 0, 0);
    push_word(wps_pkg::MODE_TICK, 0, 0, 0);
    push_word(wps_pkg::MODE_TICK, 524287, -524288, 4095);
    push_word(wps_pkg::MODE_TICK, -524288, 524287, 2880);
    push_word(wps_pkg::MODE_TICK, 100, -100, -2880);
    push_word(wps_pkg::MODE_TICK, 5000, 5000, 0);
    wait_idle();

    // looping: target straight behind for the half-turn boundary
    reg_write(wps_pkg::REG_REPEAT, 1);
    push_word(wps_pkg::MODE_TICK, 100000, 0, 0);
    push_word(wps_pkg::MODE_TICK, 100000, 0, -2880);
    push_word(wps_pkg::MODE_TICK, -100000, 0, 2880);
    push_word(wps_pkg::MODE_TICK, 0, 100000, -4096);
    push_word(wps_pkg::MODE_TICK, 0, -100000, 4095);
    push_word(wps_pkg::MODE_TICK, 300, 0, 0);
    push_word(wps_pkg::MODE_TICK, -524288, -524288, 1000);
    random_words(100, 20, 400);
    wait_idle();

    reg_write(wps_pkg::REG_REPEAT, 0);
    reg_write(wps_pkg::REG_RADIUS, 65535);
    random_words(100, 15, 60000);
    wait_idle();

    reg_write(wps_pkg::REG_REPEAT, 1);
    reg_write(wps_pkg::REG_RADIUS, 0);
    random_words(100, 40, 1);
    wait_idle();

    reg_write(wps_pkg::REG_REPEAT, 0);
    reg_write(wps_pkg::REG_RADIUS, $urandom_range(500, 5000));
    random_words(130, 10, 3000);
    wait_idle();

    $display("run covered %0d steering commands and %0d waypoint loads,", ticks_checked,
             loads_sent);
    $display("with %0d waypoints stored and patrol looping on and off", wp_count);
    if (errors == 0) begin
      $display("waypoint_patrol_steering_core_test OK");
    end else begin
      $display("waypoint_patrol_steering_core_test NOT OK");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/wps_pkg.sv
src/wps_ram.sv
src/waypoint_patrol_steering_core.sv
test/waypoint_patrol_steering_core_test.sv
